/* rtl/core/acache_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acache_pkg
// Shared types, codes and widths of the associative key/value cache.
// ----------------------------------------------------------------------------
package acache_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int RANK_W      = 6;   // holds an entry index or age rank, up to 64 entries
	localparam int CNT_W       = 16;
	localparam int OCC_OUT_W   = 5;
	localparam int CFG_W       = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int POL_W       = 2;
	localparam int OP_W        = 2;

	localparam logic [CNT_W-1:0] USE_MAX = '1;

	localparam logic [OP_W-1:0] OP_GET    = 2'd0;
	localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

	localparam logic [POL_W-1:0] POL_LRU  = 2'd0;
	localparam logic [POL_W-1:0] POL_LFU  = 2'd1;
	localparam logic [POL_W-1:0] POL_FIFO = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;

	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_HIT    = 3'd1;
	localparam logic [2:0] CMD_INSERT = 3'd2;
	localparam logic [2:0] CMD_DROP   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] lookup_key;
		logic [VAL_W-1:0] write_value;
	} acache_in_t;

	typedef struct packed {
		logic                 found;
		logic [VAL_W-1:0]     read_value;
		logic                 evicted;
		logic [KEY_W-1:0]     evicted_key;
		logic [VAL_W-1:0]     evicted_value;
		logic [OCC_OUT_W-1:0] occupancy;
	} acache_out_t;

	// search token passed along the row of cells
	typedef struct packed {
		logic              hit;
		logic [RANK_W-1:0] hit_idx;
		logic [RANK_W-1:0] hit_rank;
		logic              best;
		logic [RANK_W-1:0] best_idx;
		logic [RANK_W-1:0] best_rank;
		logic [CNT_W-1:0]  best_cnt;
	} acache_tok_t;

	// update broadcast to every cell
	typedef struct packed {
		logic [2:0]        kind;
		logic [RANK_W-1:0] idx;
		logic [RANK_W-1:0] vidx;
		logic [RANK_W-1:0] rank;
		logic              evict;
		logic              newest;
		logic              bump;
		logic              wr;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} acache_cmd_t;

endpackage

/* rtl/core/acache_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acache_cell
// One cache entry: holds key, value, age rank and use count, folds itself
// into the search token and applies broadcast updates.
// ----------------------------------------------------------------------------
module acache_cell #(
	parameter int INDEX = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  acache_pkg::acache_tok_t         tok_in,
	output acache_pkg::acache_tok_t         tok_out,
	input  logic [acache_pkg::KEY_W-1:0]    key,
	input  logic [acache_pkg::POL_W-1:0]    policy,
	input  acache_pkg::acache_cmd_t         cmd,
	output logic                            valid,
	output logic [acache_pkg::KEY_W-1:0]    key_out,
	output logic [acache_pkg::VAL_W-1:0]    value_out
);

	localparam logic [acache_pkg::RANK_W-1:0] MY_IDX = acache_pkg::RANK_W'(INDEX);

	logic                              valid_q;
	logic [acache_pkg::KEY_W-1:0]      key_q;
	logic [acache_pkg::VAL_W-1:0]      value_q;
	logic [acache_pkg::RANK_W-1:0]     rank_q;
	logic [acache_pkg::CNT_W-1:0]      cnt_q;
	acache_pkg::acache_tok_t           tok_q;
	acache_pkg::acache_tok_t           tok_d;
	logic                              take;

	always_comb begin
		tok_d = tok_in;
		if (!tok_in.hit && valid_q && key_q == key) begin
			tok_d.hit      = 1'b1;
			tok_d.hit_idx  = MY_IDX;
			tok_d.hit_rank = rank_q;
		end
		take = 1'b0;
		if (valid_q) begin
			if (!tok_in.best) begin
				take = 1'b1;
			end else if (policy == acache_pkg::POL_LFU) begin
				take = (cnt_q < tok_in.best_cnt) ||
					(cnt_q == tok_in.best_cnt && rank_q > tok_in.best_rank);
			end else begin
				take = rank_q > tok_in.best_rank;
			end
		end
		if (take) begin
			tok_d.best      = 1'b1;
			tok_d.best_idx  = MY_IDX;
			tok_d.best_rank = rank_q;
			tok_d.best_cnt  = cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd.kind)
				acache_pkg::CMD_INSERT: begin
					if (cmd.idx == MY_IDX) begin
						valid_q <= 1'b1;
					end else if (cmd.evict && cmd.vidx == MY_IDX) begin
						valid_q <= 1'b0;
					end
				end
				acache_pkg::CMD_DROP: begin
					if (cmd.idx == MY_IDX) begin
						valid_q <= 1'b0;
					end
				end
				acache_pkg::CMD_CLEAR: begin
					valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.kind)
			acache_pkg::CMD_HIT: begin
				if (cmd.idx == MY_IDX) begin
					if (cmd.wr) begin
						value_q <= cmd.value;
					end
					if (cmd.bump && cnt_q != acache_pkg::USE_MAX) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (cmd.newest) begin
						rank_q <= '0;
					end
				end else if (cmd.newest && valid_q && rank_q < cmd.rank) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			acache_pkg::CMD_INSERT: begin
				if (cmd.idx == MY_IDX) begin
					key_q   <= cmd.key;
					value_q <= cmd.value;
					rank_q  <= '0;
					cnt_q   <= acache_pkg::CNT_W'(1);
				end else if (valid_q && !(cmd.evict && cmd.vidx == MY_IDX)) begin
					// victim leaves, newcomer arrives: older entries close the gap
					if (!(cmd.evict && rank_q > cmd.rank)) begin
						rank_q <= rank_q + 1'b1;
					end
				end
			end
			acache_pkg::CMD_DROP: begin
				if (cmd.idx != MY_IDX && valid_q && rank_q > cmd.rank) begin
					rank_q <= rank_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign tok_out   = tok_q;
	assign valid     = valid_q;
	assign key_out   = key_q;
	assign value_out = value_q;

endmodule

/* rtl/core/assoc_cache_lru_lfu_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_cache_lru_lfu_fifo
// Fully associative key/value cache with LRU, LFU or FIFO replacement.
// ----------------------------------------------------------------------------
// Usage: items (get, put, remove, clear) enter on in_data when in_valid is
// high and in_stall low; one result item per input leaves on out_data when
// out_valid is high and out_stall low.
// A search token walks the row of ENTRIES cells, one cell a cycle, finding the
// hit and the replacement victim; an update step (ST_APPLY) then broadcasts the
// update and loads the output register. in_stall stays high from acceptance
// until that update step is done, so a new item waits until the last is through.
// The next item may be accepted while a result waits in the output register;
// a held result stalls only the update step of the following item.
// cfg_valid/cfg_ready writes policy (index 0) and capacity (index 1); ready
// is always high and writes belong to idle periods.
// Reset empties the cache, selects LRU and a capacity of 16 (full at the default
// ENTRIES); stale entries need no clearing pass since only valid entries are read.
// ----------------------------------------------------------------------------
module assoc_cache_lru_lfu_fifo #(
	parameter int ENTRIES = acache_pkg::ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  acache_pkg::acache_in_t              in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output acache_pkg::acache_out_t             out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [acache_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [acache_pkg::CFG_W-1:0]        cfg_data
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int OCC_W = $clog2(ENTRIES + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0]                        state_q;
	logic [OCC_W-1:0]                  scan_q;
	logic [OCC_W-1:0]                  occ_q;
	logic [acache_pkg::POL_W-1:0]      policy_q;
	logic [acache_pkg::CFG_W-1:0]      cap_q;
	acache_pkg::acache_in_t            req_q;
	logic                              out_valid_q;
	acache_pkg::acache_out_t           out_q;

	acache_pkg::acache_tok_t           tok [ENTRIES+1];
	acache_pkg::acache_cmd_t           cmd;
	logic [ENTRIES-1:0]                cell_valid;
	logic [acache_pkg::KEY_W-1:0]      cell_key [ENTRIES];
	logic [acache_pkg::VAL_W-1:0]      cell_value [ENTRIES];

	acache_pkg::acache_tok_t           fin;
	logic [OCC_W-1:0]                  cap;
	logic                              apply_go;
	logic                              do_evict;
	logic [ENTRIES-1:0]                free_vec;
	logic [IDX_W-1:0]                  slot;
	logic                              slot_found;
	logic [OCC_W-1:0]                  occ_new;
	acache_pkg::acache_out_t           res;
	logic                              in_take;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign tok[0] = '0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		acache_cell #(
			.INDEX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok[g]),
			.tok_out  (tok[g+1]),
			.key      (req_q.lookup_key),
			.policy   (policy_q),
			.cmd      (cmd),
			.valid    (cell_valid[g]),
			.key_out  (cell_key[g]),
			.value_out(cell_value[g])
		);
	end

	assign fin      = tok[ENTRIES];
	assign apply_go = (state_q == ST_APPLY) && !(out_valid_q && out_stall);

	always_comb begin
		if (cap_q == '0) begin
			cap = OCC_W'(1);
		end else if (int'(cap_q) > ENTRIES) begin
			cap = OCC_W'(ENTRIES);
		end else begin
			cap = OCC_W'(cap_q);
		end
	end

	always_comb begin
		do_evict = (req_q.operation == acache_pkg::OP_PUT) && !fin.hit &&
			(occ_q >= cap) && fin.best;
		free_vec = ~cell_valid;
		if (do_evict) begin
			free_vec[IDX_W'(fin.best_idx)] = 1'b1;
		end
		slot       = '0;
		slot_found = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!slot_found && free_vec[i]) begin
				slot_found = 1'b1;
				slot       = IDX_W'(i);
			end
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.kind   = acache_pkg::CMD_NONE;
		cmd.key    = req_q.lookup_key;
		cmd.value  = req_q.write_value;
		res        = '0;
		occ_new    = occ_q;
		unique case (req_q.operation)
			acache_pkg::OP_GET: begin
				if (fin.hit) begin
					res.found      = 1'b1;
					res.read_value = cell_value[IDX_W'(fin.hit_idx)];
					cmd.kind   = acache_pkg::CMD_HIT;
					cmd.idx    = fin.hit_idx;
					cmd.rank   = fin.hit_rank;
					cmd.newest = (policy_q == acache_pkg::POL_LRU) ||
						(policy_q == acache_pkg::POL_LFU);
					cmd.bump   = (policy_q == acache_pkg::POL_LFU);
				end
			end
			acache_pkg::OP_PUT: begin
				if (fin.hit) begin
					res.found  = 1'b1;
					cmd.kind   = acache_pkg::CMD_HIT;
					cmd.idx    = fin.hit_idx;
					cmd.rank   = fin.hit_rank;
					cmd.wr     = 1'b1;
					cmd.newest = (policy_q == acache_pkg::POL_LRU);
				end else if (slot_found) begin
					cmd.kind  = acache_pkg::CMD_INSERT;
					cmd.idx   = acache_pkg::RANK_W'(slot);
					cmd.vidx  = fin.best_idx;
					cmd.rank  = fin.best_rank;
					cmd.evict = do_evict;
					if (do_evict) begin
						res.evicted       = 1'b1;
						res.evicted_key   = cell_key[IDX_W'(fin.best_idx)];
						res.evicted_value = cell_value[IDX_W'(fin.best_idx)];
					end else begin
						occ_new = occ_q + 1'b1;
					end
				end
			end
			acache_pkg::OP_REMOVE: begin
				if (fin.hit) begin
					res.found = 1'b1;
					cmd.kind  = acache_pkg::CMD_DROP;
					cmd.idx   = fin.hit_idx;
					cmd.rank  = fin.hit_rank;
					occ_new   = occ_q - 1'b1;
				end
			end
			acache_pkg::OP_CLEAR: begin
				cmd.kind = acache_pkg::CMD_CLEAR;
				occ_new  = '0;
			end
		endcase
		res.occupancy = acache_pkg::OCC_OUT_W'(occ_new);
		if (!apply_go) begin
			cmd.kind = acache_pkg::CMD_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q <= in_data;
		end
		if (apply_go) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			occ_q       <= '0;
			policy_q    <= acache_pkg::POL_LRU;
			cap_q       <= acache_pkg::CFG_W'(16);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == acache_pkg::REG_POLICY) begin
					policy_q <= cfg_data[acache_pkg::POL_W-1:0];
				end else if (cfg_index == acache_pkg::REG_CAPACITY) begin
					cap_q <= cfg_data;
				end
			end
			if (apply_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
					end
				end
				ST_SCAN: begin
					// token advances one cell a cycle until it reaches the end of the row
					if (scan_q == OCC_W'(ENTRIES - 1)) begin
						state_q <= ST_APPLY;
					end
					scan_q <= scan_q + 1'b1;
				end
				ST_APPLY: begin
					if (apply_go) begin
						occ_q   <= occ_new;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* dv/tb_assoc_cache_lru_lfu_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_assoc_cache_lru_lfu_fifo
// Self-checking bench for the associative key/value cache: a directed table of
// operations, then random get/put/remove/clear traffic over a small key pool,
// each result compared against a behavioural model of the replacement logic.
// ----------------------------------------------------------------------------
module tb_assoc_cache_lru_lfu_fifo;

	localparam int NE = 16;
	localparam int LAT = NE + 4;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [acache_pkg::POL_W-1:0] POL_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	acache_pkg::acache_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	acache_pkg::acache_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [acache_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [acache_pkg::CFG_W-1:0] cfg_data = '0;

	assoc_cache_lru_lfu_fifo dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model state
	logic [acache_pkg::POL_W-1:0] m_policy;
	logic [acache_pkg::CFG_W-1:0] m_cap;
	bit                           m_valid [NE];
	logic [acache_pkg::KEY_W-1:0] m_key [NE];
	logic [acache_pkg::VAL_W-1:0] m_val [NE];
	int                           m_rank [NE];
	logic [acache_pkg::CNT_W-1:0] m_cnt [NE];

	acache_pkg::acache_out_t result_q[$];
	int errors = 0;
	int checked = 0;
	int evictions = 0;
	longint cycles = 0;
	bit drain = 1'b0;
	bit hold_rx = 1'b0;
	bit quiet = 1'b0;

	typedef struct {
		logic [acache_pkg::OP_W-1:0]  op;
		logic [acache_pkg::KEY_W-1:0] key;
		logic [acache_pkg::VAL_W-1:0] value;
		bit                           typed;
		acache_pkg::acache_out_t      exp;
	} row_t;

	row_t tbl[$];

	function automatic int occ_now();
		int n = 0;
		for (int i = 0; i < NE; i++) if (m_valid[i]) n++;
		return n;
	endfunction

	function automatic void to_front(int h);
		int r = m_rank[h];
		for (int j = 0; j < NE; j++)
			if (m_valid[j] && j != h && m_rank[j] < r) m_rank[j]++;
		m_rank[h] = 0;
	endfunction

	function automatic void unlink(int h);
		int r = m_rank[h];
		m_valid[h] = 0;
		for (int j = 0; j < NE; j++)
			if (m_valid[j] && m_rank[j] > r) m_rank[j]--;
	endfunction

	function automatic int choose_victim();
		int b = -1;
		for (int i = 0; i < NE; i++) begin
			if (!m_valid[i]) continue;
			if (b < 0) b = i;
			else if (m_policy == acache_pkg::POL_LFU) begin
				if (m_cnt[i] < m_cnt[b] || (m_cnt[i] == m_cnt[b] && m_rank[i] > m_rank[b]))
					b = i;
			end else if (m_rank[i] > m_rank[b]) b = i;
		end
		return b;
	endfunction

	function automatic acache_pkg::acache_out_t cache_op(acache_pkg::acache_in_t it);
		acache_pkg::acache_out_t r = '0;
		int h = -1;
		int cap, v, slot;
		for (int i = 0; i < NE; i++)
			if (h < 0 && m_valid[i] && m_key[i] == it.lookup_key) h = i;
		cap = m_cap;
		if (cap < 1) cap = 1;
		if (cap > NE) cap = NE;
		case (it.operation)
			acache_pkg::OP_GET: if (h >= 0) begin
				r.found = 1'b1;
				r.read_value = m_val[h];
				if (m_policy == acache_pkg::POL_LRU) to_front(h);
				else if (m_policy == acache_pkg::POL_LFU) begin
					if (m_cnt[h] != acache_pkg::USE_MAX) m_cnt[h]++;
					to_front(h);
				end
			end
			acache_pkg::OP_PUT: if (h >= 0) begin
				r.found = 1'b1;
				m_val[h] = it.write_value;
				if (m_policy == acache_pkg::POL_LRU) to_front(h);
			end else begin
				if (occ_now() >= cap) begin
					v = choose_victim();
					if (v >= 0) begin
						r.evicted = 1'b1;
						r.evicted_key = m_key[v];
						r.evicted_value = m_val[v];
						unlink(v);
					end
				end
				slot = -1;
				for (int i = 0; i < NE; i++) if (slot < 0 && !m_valid[i]) slot = i;
				if (slot >= 0) begin
					for (int j = 0; j < NE; j++) if (m_valid[j]) m_rank[j]++;
					m_valid[slot] = 1;
					m_key[slot] = it.lookup_key;
					m_val[slot] = it.write_value;
					m_rank[slot] = 0;
					m_cnt[slot] = acache_pkg::CNT_W'(1);
				end
			end
			acache_pkg::OP_REMOVE: if (h >= 0) begin
				r.found = 1'b1;
				unlink(h);
			end
			default: for (int i = 0; i < NE; i++) m_valid[i] = 0;
		endcase
		r.occupancy = acache_pkg::OCC_OUT_W'(occ_now());
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// receiver side: compare every accepted result item
	always @(posedge clk) begin
		acache_pkg::acache_out_t e;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0)
				report_mismatch("unexpected item", 64'(out_data.evicted_key), 64'd0);
			else begin
				e = result_q.pop_front();
				checked++;
				if (out_data.evicted) evictions++;
				if (out_data.found !== e.found)
					report_mismatch("found", 64'(out_data.found), 64'(e.found));
				if (out_data.read_value !== e.read_value)
					report_mismatch("read_value", 64'(out_data.read_value),
						64'(e.read_value));
				if (out_data.evicted !== e.evicted)
					report_mismatch("evicted", 64'(out_data.evicted), 64'(e.evicted));
				if (out_data.evicted_key !== e.evicted_key)
					report_mismatch("evicted_key", 64'(out_data.evicted_key),
						64'(e.evicted_key));
				if (out_data.evicted_value !== e.evicted_value)
					report_mismatch("evicted_value", 64'(out_data.evicted_value),
						64'(e.evicted_value));
				if (out_data.occupancy !== e.occupancy)
					report_mismatch("occupancy", 64'(out_data.occupancy),
						64'(e.occupancy));
			end
		end
	end

	// stall bursts, and one long hold when asked
	initial begin : rx_idle
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				hold_rx = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycles);
		$display("Test completed with failures");
		$finish;
	end

	task automatic send(acache_pkg::acache_in_t it, bit gaps);
		int n;
		if (gaps && !quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		result_q = {result_q, cache_op(it)};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		wait (result_q.size() == 0);
		repeat (LAT) @(posedge clk);
	endtask

	task automatic write_reg(logic [acache_pkg::CFG_IDX_W-1:0] idx,
			logic [acache_pkg::CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == acache_pkg::REG_POLICY) m_policy = val[acache_pkg::POL_W-1:0];
		else m_cap = val;
	endtask

	function automatic acache_pkg::acache_out_t mk(bit f, logic [acache_pkg::VAL_W-1:0] rv,
			bit ev, logic [acache_pkg::KEY_W-1:0] ek,
			logic [acache_pkg::VAL_W-1:0] evv, int occ);
		acache_pkg::acache_out_t r;
		r.found = f; r.read_value = rv; r.evicted = ev;
		r.evicted_key = ek; r.evicted_value = evv;
		r.occupancy = acache_pkg::OCC_OUT_W'(occ);
		return r;
	endfunction

	function automatic void add_row(logic [acache_pkg::OP_W-1:0] op,
			logic [acache_pkg::KEY_W-1:0] key, logic [acache_pkg::VAL_W-1:0] value,
			bit typed, acache_pkg::acache_out_t exp);
		row_t r;
		r.op = op; r.key = key; r.value = value; r.typed = typed; r.exp = exp;
		tbl = {tbl, r};
	endfunction

	// random phase: keys drawn from a small pool so hits and evictions are common
	task automatic random_phase(int count, int pool);
		acache_pkg::acache_in_t it;
		int p;
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(0, 99);
			if (p < 40) it.operation = acache_pkg::OP_GET;
			else if (p < 82) it.operation = acache_pkg::OP_PUT;
			else if (p < 97) it.operation = acache_pkg::OP_REMOVE;
			else it.operation = acache_pkg::OP_CLEAR;
			it.lookup_key = ($urandom_range(0, 9) == 0) ? $urandom()
				: (32'hA5000000 ^ $urandom_range(0, pool - 1));
			if ($urandom_range(0, 7) == 0) it.lookup_key = ~it.lookup_key;
			it.write_value = $urandom();
			send(it, 1);
		end
	endtask

	initial begin : stim
		row_t rw;
		acache_pkg::acache_in_t it;
		acache_pkg::acache_out_t got_exp;
		logic [acache_pkg::POL_W-1:0] pols[4];
		pols[0] = acache_pkg::POL_LRU;
		pols[1] = acache_pkg::POL_LFU;
		pols[2] = acache_pkg::POL_FIFO;
		pols[3] = POL_SPARE;
		m_policy = acache_pkg::POL_LRU;
		m_cap = acache_pkg::CFG_W'(16);
		for (int i = 0; i < NE; i++) m_valid[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, default LRU and full capacity
		add_row(acache_pkg::OP_GET, 32'h0, 32'h0, 1,
			mk(1'b0, 32'h0, 1'b0, 32'h0, 32'h0, 0));
		add_row(acache_pkg::OP_REMOVE, 32'hFFFFFFFF, 32'h0, 1,
			mk(1'b0, 32'h0, 1'b0, 32'h0, 32'h0, 0));
		add_row(acache_pkg::OP_PUT, 32'h0, 32'hFFFFFFFF, 1,
			mk(1'b0, 32'h0, 1'b0, 32'h0, 32'h0, 1));
		add_row(acache_pkg::OP_PUT, 32'hFFFFFFFF, 32'h0, 1,
			mk(1'b0, 32'h0, 1'b0, 32'h0, 32'h0, 2));
		add_row(acache_pkg::OP_GET, 32'h0, 32'h0, 1,
			mk(1'b1, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0, 2));
		add_row(acache_pkg::OP_GET, 32'hFFFFFFFF, 32'h5, 1,
			mk(1'b1, 32'h0, 1'b0, 32'h0, 32'h0, 2));
		add_row(acache_pkg::OP_PUT, 32'h0, 32'h12345678, 1,
			mk(1'b1, 32'h0, 1'b0, 32'h0, 32'h0, 2));
		add_row(acache_pkg::OP_REMOVE, 32'hFFFFFFFF, 32'h0, 1,
			mk(1'b1, 32'h0, 1'b0, 32'h0, 32'h0, 1));
		add_row(acache_pkg::OP_REMOVE, 32'hFFFFFFFF, 32'h0, 1,
			mk(1'b0, 32'h0, 1'b0, 32'h0, 32'h0, 1));
		for (int k = 0; k < 17; k++)
			add_row(acache_pkg::OP_PUT, 32'h100 + 32'(k), 32'hC0DE0000 + 32'(k), 0, '0);
		add_row(acache_pkg::OP_CLEAR, 32'h0, 32'h0, 1,
			mk(1'b0, 32'h0, 1'b0, 32'h0, 32'h0, 0));
		foreach (tbl[i]) begin
			rw = tbl[i];
			it.operation = rw.op; it.lookup_key = rw.key; it.write_value = rw.value;
			send(it, 0);
			got_exp = result_q[$];
			if (rw.typed && got_exp !== rw.exp) report_mismatch("table row", 64'(i), 64'd0);
		end
		settle();

		// full store under pressure: receiver holds off while items keep coming
		hold_rx = 1;
		random_phase(40, 24);
		settle();

		// sweep policies and capacities, extremes included
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(acache_pkg::REG_POLICY, acache_pkg::CFG_W'(pols[ph % 4]));
			case (ph % 6)
				0: write_reg(acache_pkg::REG_CAPACITY, 5'd1);
				1: write_reg(acache_pkg::REG_CAPACITY, 5'd16);
				2: write_reg(acache_pkg::REG_CAPACITY, 5'd0);
				3: write_reg(acache_pkg::REG_CAPACITY, 5'd31);
				default: write_reg(acache_pkg::REG_CAPACITY,
					acache_pkg::CFG_W'($urandom_range(2, 15)));
			endcase
			random_phase(55, (ph % 2) ? 12 : 28);
			// shrink capacity below occupancy without clearing
			if (ph == 5) begin
				settle();
				write_reg(acache_pkg::REG_CAPACITY, 5'd3);
				random_phase(20, 30);
			end
			settle();
		end

		// last stretch with no idling on either side
		quiet = 1;
		write_reg(acache_pkg::REG_POLICY, acache_pkg::CFG_W'(acache_pkg::POL_LFU));
		write_reg(acache_pkg::REG_CAPACITY, 5'd8);
		random_phase(60, 14);
		settle();

		$display("covered %0d results (%0d with evictions) over LRU, LFU, FIFO and",
			checked, evictions);
		$display("the unused policy code, capacities 0, 1, 3, 16, 31 and random sizes");
		if (errors == 0 && result_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
